FILE: hw/rtl/lhs_pkg.sv
// Shared types and constants for the lane histogram steering block.
// Depends on nothing; every other file in hw/rtl imports it.
package lhs_pkg;

    // Histogram storage.
    localparam int MAX_COLUMNS = 512;
    localparam int ADDR_W      = $clog2(MAX_COLUMNS);
    localparam int CMP_W       = (ADDR_W + 1 > 10) ? ADDR_W + 1 : 10;
    localparam int CNT_W       = 7;
    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_COLUMNS - 1);

    // Stream widths.
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] TOP_CNT_MAX = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BAND_TOP           = 3'd0,
        REG_BAND_ROWS          = 3'd1,
        REG_FRAME_WIDTH        = 3'd2,
        REG_LEFT_SEARCH_END    = 3'd3,
        REG_RIGHT_SEARCH_START = 3'd4,
        REG_FRAME_CENTER       = 3'd5,
        REG_END_THRESHOLD      = 3'd6,
        REG_FINE_STEP          = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        STEER_FWD          = 3'd0,
        STEER_RIGHT_FINE   = 3'd1,
        STEER_RIGHT_MID    = 3'd2,
        STEER_RIGHT_COARSE = 3'd3,
        STEER_LEFT_FINE    = 3'd4,
        STEER_LEFT_MID     = 3'd5,
        STEER_LEFT_COARSE  = 3'd6,
        STEER_LANE_END     = 3'd7
    } steer_code_t;

    // Request to the column count memory.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CNT_W-1:0]  wr_data;
    } ram_req_t;

    // One column count coming out of the memory during the peak scan.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  count;
    } samp_t;

endpackage

FILE: hw/rtl/lhs_col_ram.sv
// Column count memory: one write port and one registered read port.
// Depends on lhs_pkg.
module lhs_col_ram import lhs_pkg::*; (
    input  logic             aclk,
    input  ram_req_t         req,
    output logic [CNT_W-1:0] rd_data
);

    logic [CNT_W-1:0] mem [MAX_COLUMNS];
    logic [CNT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/lhs_peak.sv
// Running first-maximum search over the left and right column windows.
// Depends on lhs_pkg.
module lhs_peak import lhs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             init,
    input  samp_t            samp,
    input  logic [CMP_W-1:0] left_lim,
    input  logic [CMP_W-1:0] width_lim,
    input  logic [8:0]       right_start,
    output logic [8:0]       left_pos,
    output logic [8:0]       right_pos
);

    logic [CMP_W-1:0] l_pos_reg, r_pos_reg;
    logic [CNT_W-1:0] l_max_reg, r_max_reg;
    logic             l_found_reg, r_found_reg;
    logic [CMP_W-1:0] addr_ext;
    logic             in_left, in_right, l_take, r_take;

    assign addr_ext = CMP_W'(samp.addr);
    assign in_left  = addr_ext < left_lim;
    assign in_right = (addr_ext >= CMP_W'(right_start)) && (addr_ext < width_lim);
    // Strictly greater keeps the lowest column among equal counts.
    assign l_take = samp.valid && in_left && (!l_found_reg || samp.count > l_max_reg);
    assign r_take = samp.valid && in_right && (!r_found_reg || samp.count > r_max_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l_found_reg <= 1'b0;
            r_found_reg <= 1'b0;
        end else if (init) begin
            l_found_reg <= 1'b0;
            r_found_reg <= 1'b0;
        end else begin
            if (l_take) l_found_reg <= 1'b1;
            if (r_take) r_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (init) begin
            l_pos_reg <= '0;
            r_pos_reg <= CMP_W'(right_start);
        end else begin
            if (l_take) begin
                l_pos_reg <= addr_ext;
                l_max_reg <= samp.count;
            end
            if (r_take) begin
                r_pos_reg <= addr_ext;
                r_max_reg <= samp.count;
            end
        end
    end

    assign left_pos  = l_pos_reg[8:0];
    assign right_pos = r_pos_reg[8:0];

endmodule

FILE: hw/rtl/lhs_steer.sv
// Lane center, offset from the frame center and steering quantization.
// Depends on lhs_pkg.
module lhs_steer import lhs_pkg::*; (
    input  logic        aclk,
    input  logic [8:0]  left_pos,
    input  logic [8:0]  right_pos,
    input  logic [8:0]  frame_center,
    input  logic [7:0]  fine_step,
    input  logic        lane_end,
    output logic [8:0]  lane_center,
    output logic [9:0]  offset,
    output steer_code_t steer_code
);

    logic signed [10:0] diff, half, center_s, off_s;
    logic signed [10:0] o, f1, f2;
    logic [8:0]         center_reg;
    logic [9:0]         offset_reg;

    // The half difference rounds toward zero, so negative gaps add one first.
    always_comb begin
        diff     = signed'({2'b00, right_pos}) - signed'({2'b00, left_pos});
        half     = (diff + signed'({10'd0, diff[10]})) >>> 1;
        center_s = signed'({2'b00, left_pos}) + half;
        off_s    = center_s - signed'({2'b00, frame_center});
    end

    always_ff @(posedge aclk) begin
        center_reg <= center_s[8:0];
        offset_reg <= off_s[9:0];
    end

    always_comb begin
        o  = signed'({offset_reg[9], offset_reg});
        f1 = signed'({3'b000, fine_step});
        f2 = signed'({2'b00, fine_step, 1'b0});
        if (lane_end) begin
            steer_code = STEER_LANE_END;
        end else if (o == 11'sd0) begin
            steer_code = STEER_FWD;
        end else if (o > 11'sd0 && o < f1) begin
            steer_code = STEER_RIGHT_FINE;
        end else if (o >= f1 && o < f2) begin
            steer_code = STEER_RIGHT_MID;
        end else if (o > 11'sd0) begin
            steer_code = STEER_RIGHT_COARSE;
        end else if (o > -f1) begin
            steer_code = STEER_LEFT_FINE;
        end else if (o > -f2) begin
            steer_code = STEER_LEFT_MID;
        end else begin
            steer_code = STEER_LEFT_COARSE;
        end
    end

    assign lane_center = center_reg;
    assign offset      = offset_reg;

endmodule

FILE: hw/rtl/lane_histogram_steering.sv
// Top level of the lane histogram steering block: sequencer, registers, stream ports.
// Depends on lhs_pkg, lhs_col_ram, lhs_peak and lhs_steer.
//
//  Channel  | Direction | Handshake               | Contents
//  ---------+-----------+-------------------------+---------------------------------------
//  s_axis   | in        | tvalid/tready           | one mask pixel per request, tlast ends frame
//  m_axis   | out       | tvalid/tready           | one steering result per frame
//  cfg      | in        | cfg_wr_en, no wait      | register index and write data
//
// For each pixel, the request cycle reads the column count from the
// histogram memory and the next cycle writes the incremented count back.
// The pixel that ends a frame is followed by a scan of all MAX_COLUMNS memory
// entries, one per cycle through the single read port, then the drain, steer
// and emit states for the center, offset and steering code before the
// next pixel request is taken. After reset a clearing pass zeroes all
// MAX_COLUMNS memory entries with s_axis_tready low; configuration writes
// are taken throughout. A finished result waits in the output register while
// pixels of the next frame are taken; only the next frame end waits for it.
module lane_histogram_steering import lhs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input pixel stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Bits from 0: pixel_on [0], column [9:1], row [17:10], zero fill [23:18].
    input  logic [S_DATA_W-1:0]   s_axis_tdata,
    input  logic                  s_axis_tlast,
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Bits from 0: left_pos [8:0], right_pos [17:9], lane_center [26:18],
    // offset [36:27], steer_code [39:37], lane_end [40],
    // top_band_count [56:41], zero fill [63:57].
    output logic [M_DATA_W-1:0]   m_axis_tdata,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // The sequencer walks through these states one-hot.
    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_UPDATE = 7'b0000100,
        ST_SCAN   = 7'b0001000,
        ST_DRAIN  = 7'b0010000,
        ST_STEER  = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    // Configuration registers.
    logic [7:0]  band_top_reg;
    logic [6:0]  band_rows_reg;
    logic [9:0]  frame_width_reg;
    logic [9:0]  left_search_end_reg;
    logic [8:0]  right_search_start_reg;
    logic [8:0]  frame_center_reg;
    logic [15:0] end_threshold_reg;
    logic [7:0]  fine_step_reg;

    // Pixel held between the read and the write-back of its column count.
    logic [ADDR_W-1:0] pix_col_reg;
    logic              pix_hit_reg;
    logic              pix_last_reg;

    logic [15:0] top_count_reg, top_count_next;

    logic              samp_valid_reg;
    logic [ADDR_W-1:0] samp_addr_reg;

    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg;

    // Request fields and derived window limits.
    logic       s_accept, in_on;
    logic [8:0] in_col;
    logic [7:0] in_row;
    logic       lower_hit, top_hit, col_stored;
    logic [CMP_W-1:0] width_lim, left_lim;
    logic       out_free, out_load, lane_end, peak_init;

    ram_req_t         ram_req;
    logic [CNT_W-1:0] ram_rd_data;
    samp_t            samp;

    logic [8:0]  left_pos, right_pos, lane_center;
    logic [9:0]  offset;
    steer_code_t steer_code;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    assign in_on  = s_axis_tdata[0];
    assign in_col = s_axis_tdata[9:1];
    assign in_row = s_axis_tdata[17:10];

    // Frame width is clamped to the storage; the left window also ends at the width.
    assign width_lim = (CMP_W'(frame_width_reg) > CMP_W'(MAX_COLUMNS)) ?
                       CMP_W'(MAX_COLUMNS) : CMP_W'(frame_width_reg);
    assign left_lim  = (CMP_W'(left_search_end_reg) < width_lim) ?
                       CMP_W'(left_search_end_reg) : width_lim;

    // The lower band runs from band_top for band_rows rows; the sum is one bit
    // wider so a band past the last row simply ends at row 255.
    assign col_stored = CMP_W'(in_col) < CMP_W'(MAX_COLUMNS);
    assign lower_hit  = in_on && (in_row >= band_top_reg) &&
                        ({1'b0, in_row} < ({1'b0, band_top_reg} + 9'(band_rows_reg))) &&
                        col_stored;
    // The top band is the rows below band_rows, limited to the columns in use.
    assign top_hit    = in_on && (in_row < 8'(band_rows_reg)) && (CMP_W'(in_col) < width_lim);

    assign lane_end = top_count_reg > end_threshold_reg;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign out_load = (state_reg == ST_EMIT) && out_free;

    // The peak search restarts in the clear, idle and update states and holds its result from the scan through emit.
    assign peak_init = (state_reg == ST_CLEAR) || (state_reg == ST_IDLE) ||
                       (state_reg == ST_UPDATE);

    // Configuration writes; every index value names one of the eight registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_top_reg           <= 8'd140;
            band_rows_reg          <= 7'd60;
            frame_width_reg        <= 10'd300;
            left_search_end_reg    <= 10'd150;
            right_search_start_reg <= 9'd200;
            frame_center_reg       <= 9'd150;
            end_threshold_reg      <= 16'd3000;
            fine_step_reg          <= 8'd10;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                REG_BAND_TOP:           band_top_reg           <= cfg_data[7:0];
                REG_BAND_ROWS:          band_rows_reg          <= cfg_data[6:0];
                REG_FRAME_WIDTH:        frame_width_reg        <= cfg_data[9:0];
                REG_LEFT_SEARCH_END:    left_search_end_reg    <= cfg_data[9:0];
                REG_RIGHT_SEARCH_START: right_search_start_reg <= cfg_data[8:0];
                REG_FRAME_CENTER:       frame_center_reg       <= cfg_data[8:0];
                REG_END_THRESHOLD:      end_threshold_reg      <= cfg_data[15:0];
                REG_FINE_STEP:          fine_step_reg          <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Sequencer. The memory is swept once after reset and once per frame end;
    // the frame-end sweep reads each entry and zeroes it in the same cycle.
    always_comb begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        top_count_next = top_count_reg;
        ram_req        = '0;
        case (state_reg)
            ST_CLEAR: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = addr_reg;
                ram_req.wr_data = '0;
                if (addr_reg == LAST_ADDR) begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                ram_req.rd_en   = s_accept;
                ram_req.rd_addr = ADDR_W'(in_col);
                if (s_accept) begin
                    state_next = ST_UPDATE;
                    if (top_hit && top_count_reg != TOP_CNT_MAX) begin
                        top_count_next = top_count_reg + 16'd1;
                    end
                end
            end
            ST_UPDATE: begin
                // Column counts saturate rather than wrap.
                ram_req.wr_en   = pix_hit_reg && (ram_rd_data != CNT_MAX);
                ram_req.wr_addr = pix_col_reg;
                ram_req.wr_data = ram_rd_data + 1'b1;
                addr_next       = '0;
                state_next      = pix_last_reg ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = addr_reg;
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = addr_reg;
                ram_req.wr_data = '0;
                if (addr_reg == LAST_ADDR) begin
                    addr_next  = '0;
                    state_next = ST_DRAIN;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                // The last column read is folded into the peak search here.
                state_next = ST_STEER;
            end
            ST_STEER: begin
                // The steering unit registers center and offset in this cycle.
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    top_count_next = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            addr_reg       <= '0;
            top_count_reg  <= '0;
            samp_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            top_count_reg  <= top_count_next;
            samp_valid_reg <= (state_reg == ST_SCAN);
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        samp_addr_reg <= addr_reg;
        if (s_accept) begin
            pix_col_reg  <= ADDR_W'(in_col);
            pix_hit_reg  <= lower_hit;
            pix_last_reg <= s_axis_tlast;
        end
        if (out_load) begin
            m_data_reg <= {7'd0, top_count_reg, lane_end, steer_code, offset,
                           lane_center, right_pos, left_pos};
        end
    end

    assign samp.valid = samp_valid_reg;
    assign samp.addr  = samp_addr_reg;
    assign samp.count = ram_rd_data;

    lhs_col_ram u_col_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    lhs_peak u_peak (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .init        (peak_init),
        .samp        (samp),
        .left_lim    (left_lim),
        .width_lim   (width_lim),
        .right_start (right_search_start_reg),
        .left_pos    (left_pos),
        .right_pos   (right_pos)
    );

    lhs_steer u_steer (
        .aclk         (aclk),
        .left_pos     (left_pos),
        .right_pos    (right_pos),
        .frame_center (frame_center_reg),
        .fine_step    (fine_step_reg),
        .lane_end     (lane_end),
        .lane_center  (lane_center),
        .offset       (offset),
        .steer_code   (steer_code)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

FILE: hw/rtl/lhs_checker.sv
// Port-level checks for the lane histogram steering block, bound to its top level.
// Depends on lhs_pkg and lane_histogram_steering.
module lhs_checker import lhs_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                s_axis_tlast,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata
);

    // Each pixel needs a write-back cycle before the next request.
    a_pixel_two_cycles: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("pixel request taken on the write-back cycle");

    // A frame end starts the column scan, so requests stay blocked after it.
    a_scan_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |-> ##2 !s_axis_tready)
        else $error("pixel request taken during the column scan");

    // A stalled result stays in place.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Lane end and the lane-end steering code always go together.
    a_lane_end_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[40] == (m_axis_tdata[39:37] == STEER_LANE_END)))
        else $error("lane end flag and steering code disagree");

    // Without lane end, the forward code means exactly a zero offset.
    a_forward_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[40] |->
            ((m_axis_tdata[39:37] == STEER_FWD) == (m_axis_tdata[36:27] == 10'd0)))
        else $error("forward code and offset disagree");

endmodule

bind lane_histogram_steering lhs_checker u_lhs_checker (.*);
